@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/edn_pkg.sv @@
// Package: widths, sequencer states and shared types of the distance core.
`timescale 1ns / 1ps
package edn_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned MagW    = 16;
  localparam int unsigned SqW     = 2 * MagW;
  localparam int unsigned SumW    = 43;
  localparam int unsigned RadW    = SumW + 1;
  localparam int unsigned ResW    = RadW / 2;
  localparam int unsigned RemW    = ResW + 3;
  localparam int unsigned IterCnt = ResW;
  localparam int unsigned CntW    = $clog2(IterCnt);

  localparam logic [ResW-1:0] RootMax = ResW'(2965820);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT
  } edn_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } edn_sqrt_stat_t;

endpackage

@@ sv/edn_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module edn_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [edn_pkg::SumW-1:0]      radicand_i,
  output edn_pkg::edn_sqrt_stat_t       status_o,
  output logic [edn_pkg::ResW-1:0]      root_o
);
  import edn_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RadW-1:0] rad_q, rad_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [ResW-1:0] root_q, root_d;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            fits;

  // One restoring step: bring down two bits, try (root << 2) | 1.
  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rad_d  = {1'b0, radicand_i};
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      rem_d  = fits ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[ResW-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(IterCnt - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign root_o        = root_q;

endmodule

@@ sv/euclidean_distance_nd_core.sv @@
// Top level: streaming N-dimensional Euclidean distance on Q8.8 coordinates.
`timescale 1ns / 1ps
// Each input item carries one coordinate of each vector (signed Q8.8). The core
// squares the difference and adds it to a 43-bit Q27.16 running sum that
// saturates at its all-ones value. An item with last set closes the vector:
// its own term is added, the sum is cleared, and one result item follows with
// floor(sqrt(sum)), which is the distance in unsigned Q14.8. The core takes one
// item at a time: an item without last occupies it while the difference is
// captured, squared and accumulated; an item with last also while the
// square-root unit runs one iteration per root bit and then until the root is
// loaded into the output register. The result waits in that register while
// the next item is already taken; a new root is stored only once the previous
// result has left.
module euclidean_distance_nd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [edn_pkg::CoordW-1:0]   coord_a_i,
  input  logic [edn_pkg::CoordW-1:0]   coord_b_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [edn_pkg::ResW-1:0]     dist_res_o
);
  import edn_pkg::*;

  edn_state_e      state_q, state_d;
  logic [MagW-1:0] mag_q;
  logic            last_q;
  logic [SqW-1:0]  sq_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic            out_valid_q, out_valid_d;
  logic [ResW-1:0] dist_res_q;

  logic              in_take;
  logic              sqrt_start;
  logic              out_load;
  logic [CoordW:0]   diff;
  logic [MagW-1:0]   mag_d;
  logic [SumW:0]     sum_add;
  logic [SumW-1:0]   sum_sat;
  logic [ResW-1:0]   root;
  edn_sqrt_stat_t    sqrt_stat;

  // Exact 17-bit difference, then its magnitude (fits 16 bits unsigned).
  assign diff  = {coord_a_i[CoordW-1], coord_a_i} - {coord_b_i[CoordW-1], coord_b_i};
  assign mag_d = diff[CoordW] ? MagW'(-diff) : diff[MagW-1:0];

  // Add the registered square; clamp at all ones on carry out.
  assign sum_add = {1'b0, sum_q} + (SumW + 1)'(sq_q);
  assign sum_sat = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM:  state_d = last_q ? ST_ROOT : ST_IDLE;
      ST_ROOT:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: control outputs.
  always_comb begin
    in_ready_o = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SQUARE: ;
      ST_ACCUM:  sqrt_start = last_q;
      // Hold the root until the output register is free.
      ST_ROOT:   out_load = sqrt_stat.done && (!out_valid_q || out_ready_i);
      default:   ;
    endcase
  end

  assign in_take = in_valid_i && in_ready_o;

  // Clear the sum when the vector closes; its final value goes to the root unit.
  always_comb begin
    sum_d = sum_q;
    if (state_q == ST_ACCUM) begin
      sum_d = last_q ? '0 : sum_sat;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  edn_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_sat),
    .status_o   (sqrt_stat),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on take, square in the following cycle, load the result on out_load.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mag_q  <= mag_d;
      last_q <= last_i;
    end
    if (state_q == ST_SQUARE) begin
      sq_q <= SqW'(mag_q) * SqW'(mag_q);
    end
    if (out_load) begin
      dist_res_q <= root;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dist_res_o  = dist_res_q;

endmodule

@@ sv/edn_checker.sv @@
// Port-level checker for the distance core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module edn_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [edn_pkg::CoordW-1:0]   coord_a_i,
  input logic [edn_pkg::CoordW-1:0]   coord_b_i,
  input logic                         last_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [edn_pkg::ResW-1:0]     dist_res_o
);
  import edn_pkg::*;

  logic              in_take;
  logic              in_wait;
  logic [2*CoordW:0] in_payload;
  logic              out_stall;

  assign in_take    = in_valid_i && in_ready_o;
  assign in_wait    = in_valid_i && !in_ready_o;
  assign in_payload = {coord_a_i, coord_b_i, last_i};
  assign out_stall  = out_valid_o && !out_ready_i;

  // A waiting input item holds its value.
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(in_payload))
  // A waiting result holds its value.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(dist_res_o))
  // One item at a time: drop ready right after a take.
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_take, !in_ready_o)
  // A result never appears the cycle after a take.
  `ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_take, !$rose(out_valid_o))
  // The root of a saturated sum bounds every result.
  `ASSERT_ALWAYS(a_res_range, clk_i, rst_ni, !out_valid_o || (dist_res_o <= RootMax))

endmodule

bind euclidean_distance_nd_core edn_checker u_edn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .coord_a_i   (coord_a_i),
  .coord_b_i   (coord_b_i),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .dist_res_o  (dist_res_o)
);
